### hdl/cnsf_pkg.sv
// Shared types, register codes and colour distance functions for the
// colour neighbour similarity filter. No dependencies.
`default_nettype none

package cnsf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int NBR_N         = 8;
  localparam int ROW_W         = 17;

  // (d + 2) / 3 for d + 2 below 258: multiply by 171, shift by 9
  localparam logic [16:0] RECIP_3  = 17'd171;
  localparam int          RECIP_SH = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_NBR_MODE     = 2'd2
  } cfg_reg_e;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd1024;
  localparam logic        NBR_MODE_RST     = 1'b0;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        flush;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] similarity;
    logic       last_of_frame;
  } out_beat_t;

  // neighbors in raster order of the 3x3 window, center left out
  typedef struct packed {
    rgb_t                   center;
    rgb_t [NBR_N-1:0]       nbr;
    logic [NBR_N-1:0]       nbr_ok;
    logic                   last;
  } nbr_set_t;

  function automatic logic [7:0] chan_dist(logic [7:0] a, logic [7:0] b);
    logic [7:0]  d;
    logic [16:0] p;
    d = (a > b) ? (a - b) : (b - a);
    p = (17'(d) + 17'd2) * RECIP_3;
    return p[RECIP_SH +: 8];
  endfunction

  function automatic logic [7:0] colour_dist(rgb_t a, rgb_t b);
    logic [9:0] s;
    s = 10'(chan_dist(a[23:16], b[23:16])) + 10'(chan_dist(a[15:8], b[15:8]))
      + 10'(chan_dist(a[7:0], b[7:0]));
    return (s > 10'd255) ? 8'hFF : s[7:0];
  endfunction

endpackage

`default_nettype wire

### hdl/cnsf_front.sv
// Front part: configuration registers, raster counters, line store memory
// and the 3x3 window; classifies each beat and forms neighbor sets.
// Depends on cnsf_pkg.
`default_nettype none

module cnsf_front #(
  parameter int MAX_WIDTH = cnsf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cnsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cnsf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  input  wire cnsf_pkg::in_beat_t             in_data_i,
  output      logic                           in_stall_o,
  input  wire logic                           q_ready_i,
  output      logic                           q_push_o,
  output      cnsf_pkg::nbr_set_t             q_item_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = cnsf_pkg::ROW_W;

  logic [10:0]   frame_width_q;
  logic [15:0]   frame_height_q;
  logic          nbr_mode_q;
  logic [AW-1:0] col_q;
  logic [RW-1:0] row_q;

  logic [WW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [WW-1:0] col_w;
  logic          drain;
  logic          ignore;
  logic          in_acc;
  logic          take;
  cnsf_pkg::rgb_t pix;
  logic          row_ok;
  logic [RW-1:0] cr;
  logic [WW-1:0] cc;
  logic          emit;
  logic          last;
  logic          ok_top, ok_bot, ok_left, ok_right;
  logic [cnsf_pkg::NBR_N-1:0] ok;
  logic          cfg_hit;

  logic                       fb_valid_q;
  logic [AW-1:0]              fb_addr_q;
  cnsf_pkg::rgb_t             fb_pix_q;
  logic                       fb_emit_q;
  logic [cnsf_pkg::NBR_N-1:0] fb_ok_q;
  logic                       fb_last_q;
  logic                       fb_fire;

  logic [47:0]    line_mem [MAX_WIDTH];
  logic [47:0]    rd_q;
  logic           byp_q;
  logic [47:0]    byp_data_q;
  logic [47:0]    rd_word;
  logic [47:0]    wr_data;
  cnsf_pkg::rgb_t upper, middle;
  cnsf_pkg::rgb_t win_q [6];

  always_comb begin
    if (frame_width_q == 11'd0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_q);
    end
    eff_h = (frame_height_q == 16'd0) ? RW'(1) : {1'b0, frame_height_q};
  end

  assign col_w  = WW'(col_q);
  assign drain  = row_q >= eff_h;
  assign ignore = !drain && in_data_i.flush;
  assign pix    = drain ? '0 : in_data_i.pixel_rgb;
  assign in_acc = in_valid_i && !in_stall_o;
  assign take   = in_acc && !ignore;

  always_comb begin
    if (col_w != '0) begin
      row_ok = row_q != '0;
      cr     = row_q - RW'(1);
      cc     = col_w - WW'(1);
    end else begin
      row_ok = row_q >= RW'(2);
      cr     = row_q - RW'(2);
      cc     = eff_w - WW'(1);
    end
    emit     = row_ok && (cr < eff_h);
    ok_top   = cr != '0;
    ok_bot   = (cr + RW'(1)) < eff_h;
    ok_left  = cc != '0;
    ok_right = (cc + WW'(1)) < eff_w;
    last     = emit && (cr == eff_h - RW'(1)) && (cc == eff_w - WW'(1));
    ok[0] = ok_top && ok_left && nbr_mode_q;
    ok[1] = ok_top;
    ok[2] = ok_top && ok_right && nbr_mode_q;
    ok[3] = ok_left;
    ok[4] = ok_right;
    ok[5] = ok_bot && ok_left && nbr_mode_q;
    ok[6] = ok_bot;
    ok[7] = ok_bot && ok_right && nbr_mode_q;
  end

  always_comb begin
    unique case (cfg_idx_i) inside
      cnsf_pkg::REG_FRAME_WIDTH,
      cnsf_pkg::REG_FRAME_HEIGHT,
      cnsf_pkg::REG_NBR_MODE: cfg_hit = cfg_we_i;
      default:                cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= cnsf_pkg::FRAME_WIDTH_RST;
      frame_height_q <= cnsf_pkg::FRAME_HEIGHT_RST;
      nbr_mode_q     <= cnsf_pkg::NBR_MODE_RST;
      col_q          <= '0;
      row_q          <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_idx_i)
        cnsf_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[10:0];
        cnsf_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        cnsf_pkg::REG_NBR_MODE:     nbr_mode_q     <= cfg_wdata_i[0];
        default:                    nbr_mode_q     <= nbr_mode_q;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (take) begin
      if (last) begin
        col_q <= '0;
        row_q <= '0;
      end else if ((col_w + WW'(1)) >= eff_w) begin
        col_q <= '0;
        row_q <= row_q + RW'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  assign fb_fire    = fb_valid_q && (!fb_emit_q || q_ready_i);
  assign in_stall_o = fb_valid_q && !fb_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (take) begin
        fb_valid_q <= 1'b1;
        byp_q      <= fb_fire && (fb_addr_q == col_q);
      end else if (fb_fire) begin
        fb_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fb_addr_q  <= col_q;
      fb_pix_q   <= pix;
      fb_emit_q  <= emit;
      fb_ok_q    <= ok;
      fb_last_q  <= last;
      byp_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fb_fire) begin
      line_mem[fb_addr_q] <= wr_data;
    end
    if (take) begin
      rd_q <= line_mem[col_q];
    end
  end

  assign rd_word = byp_q ? byp_data_q : rd_q;
  assign upper   = rd_word[47:24];
  assign middle  = rd_word[23:0];
  assign wr_data = {middle, fb_pix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) win_q[k] <= '0;
    end else if (cfg_hit || (fb_fire && fb_last_q)) begin
      for (int k = 0; k < 6; k++) win_q[k] <= '0;
    end else if (fb_fire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= upper;
      win_q[4] <= middle;
      win_q[5] <= fb_pix_q;
    end
  end

  assign q_push_o        = fb_fire && fb_emit_q;
  assign q_item_o.center = win_q[4];
  assign q_item_o.nbr[0] = win_q[0];
  assign q_item_o.nbr[1] = win_q[3];
  assign q_item_o.nbr[2] = upper;
  assign q_item_o.nbr[3] = win_q[1];
  assign q_item_o.nbr[4] = middle;
  assign q_item_o.nbr[5] = win_q[2];
  assign q_item_o.nbr[6] = win_q[5];
  assign q_item_o.nbr[7] = fb_pix_q;
  assign q_item_o.nbr_ok = fb_ok_q;
  assign q_item_o.last   = fb_last_q;

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last && !cfg_hit) |=> (col_q == '0 && row_q == '0))
    else $error("frame did not restart after its last result");

  a_held_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fb_valid_q && !fb_fire) |=> (fb_valid_q && $stable(fb_addr_q)))
    else $error("held window beat lost or changed");

endmodule

`default_nettype wire

### hdl/cnsf_queue.sv
// Two-entry queue of neighbor sets between front and back parts.
// Depends on cnsf_pkg.
`default_nettype none

module cnsf_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire cnsf_pkg::nbr_set_t data_i,
  output      logic               ready_o,
  output      logic               valid_o,
  output      cnsf_pkg::nbr_set_t data_o,
  input  wire logic               pop_i
);

  cnsf_pkg::nbr_set_t mem_q [2];
  logic               wr_q, rd_q;
  logic [1:0]         count_q;

  assign ready_o = count_q != 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (count_q != 2'd2))
    else $error("push into full queue");

endmodule

`default_nettype wire

### hdl/cnsf_back.sv
// Back part: eight colour distances, then maximum and complement into
// the output register. Depends on cnsf_pkg.
`default_nettype none

module cnsf_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire cnsf_pkg::nbr_set_t  in_item_i,
  output      logic                in_pop_o,
  output      logic                out_valid_o,
  output      cnsf_pkg::out_beat_t out_data_o,
  input  wire logic                out_stall_i
);

  logic [7:0] dist_q [cnsf_pkg::NBR_N];
  logic       s1_last_q;
  logic       s1_valid_q;
  logic       s1_ready;
  logic       out_ready;
  logic [7:0] best;
  cnsf_pkg::out_beat_t out_q;
  logic       out_valid_q;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign in_pop_o  = in_valid_i && s1_ready;

  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      for (int k = 0; k < cnsf_pkg::NBR_N; k++) begin
        dist_q[k] <= in_item_i.nbr_ok[k] ?
                     cnsf_pkg::colour_dist(in_item_i.center, in_item_i.nbr[k]) : 8'd0;
      end
      s1_last_q <= in_item_i.last;
    end
  end

  always_comb begin
    best = 8'd0;
    for (int k = 0; k < cnsf_pkg::NBR_N; k++) begin
      if (dist_q[k] > best) best = dist_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_ready) begin
      out_q.similarity    <= 8'd255 - best;
      out_q.last_of_frame <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= in_valid_i;
      if (out_ready) out_valid_q <= s1_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> (s1_valid_q && out_valid_q))
    else $error("distance stage dropped a beat under stall");

endmodule

`default_nettype wire

### hdl/color_neighbor_similarity_filter_top.sv
// Top level of the colour neighbour similarity filter.
// Depends on cnsf_pkg, cnsf_front, cnsf_queue, cnsf_back.
//
// Usage: RGB pixels arrive in raster order on the in channel (valid/stall),
// results leave on the out channel (valid/stall). Each result is 255 minus
// the largest colour distance from a pixel to its in-frame neighbors
// (4- or 8-connected by register). The result for a pixel is produced by
// the beat one row plus one pixel later; frame_width + 1 flush beats after
// the last pixel drain the frame, and last_of_frame marks its final result.
// Throughput: one beat per cycle while the output is not stalled. An input
// beat's result passes the window register, queue, distance stage and output
// register. The line store memory read is registered and forwarded when
// it hits the entry being written in the same cycle.
// Configuration writes restart the frame counters and clear the window;
// line stores keep their contents. Reset restores register defaults and
// empties all stages; line stores need no clearing.
// When the receiver stalls, the output register, the distance stage and
// the two-entry queue fill, then the input stalls; no beat is lost.
`default_nettype none

module color_neighbor_similarity_filter_top #(
  parameter int MAX_WIDTH = cnsf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cnsf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cnsf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  input  wire cnsf_pkg::in_beat_t              in_data_i,
  output      logic                            in_stall_o,
  output      logic                            out_valid_o,
  output      cnsf_pkg::out_beat_t             out_data_o,
  input  wire logic                            out_stall_i
);

  logic               q_push, q_ready, q_valid, q_pop;
  cnsf_pkg::nbr_set_t q_in, q_out;

  cnsf_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  cnsf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .data_o (q_out),
    .pop_i  (q_pop)
  );

  cnsf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_item_i  (q_out),
    .in_pop_o   (q_pop),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

endmodule

`default_nettype wire
